[rtl/lzss_pkg.sv]
`timescale 1ns / 1ps

package lzss_pkg;

    // Default window and length field sizes
    localparam int WINDOW_AW_DEF   = 8;
    localparam int MATCH_LEN_W_DEF = 4;

    // Token and stream constants
    localparam int MIN_MATCH      = 2;
    localparam int START_POSITION = 239;
    localparam int LITERAL_BITS   = 8;
    localparam int MAX_RESULTS    = 17;
    localparam int ACC_CAPACITY   = 64;
    localparam int HELD_W         = $clog2(ACC_CAPACITY + 1);
    localparam int COUNT_W        = $clog2(MAX_RESULTS + 1);
    localparam int OUT_LEN_W      = 32;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;         // take the accepted byte into the bit buffer
        logic restart;      // restart the stream before the byte is taken
        logic lit_emit;     // decode a literal token and emit its byte
        logic match_parse;  // decode a match token into source and count
        logic copy_read;    // read the window at the copy source
        logic copy_emit;    // emit the byte read from the window
        logic flush_push;   // move the held byte to the output, marked last
        logic finish;       // close the step, drop a copy if stream is done
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic done;          // produced count has reached output length
        logic copy_pending;  // copy bytes still to emit
        logic lit_ready;     // a whole literal token is buffered
        logic match_ready;   // a whole match token is buffered
        logic pend_valid;    // a byte of this step waits in the hold stage
        logic out_free;      // output register can take a byte this cycle
    } t_dp_stat;

endpackage

[rtl/lzss_ring_decompressor_top.sv]
`timescale 1ns / 1ps

// LZSS decompressor with a ring window of 2^WINDOW_AW bytes, written from
// position 239 after reset or a restart. One compressed byte is taken per
// transfer when the block is idle, its bits read most significant first; a
// set flag bit starts an 8-bit literal, a clear one a window position and a
// length (copy of length + 2 bytes). Output bytes pass a one-byte hold stage
// and a one-deep output register, tlast on the last byte caused by an input
// byte, tuser on a byte that reaches output_length. Each input byte is
// accepted, then each literal is emitted, each match token decoded, each
// copied byte read from the window and then emitted, and the step closes
// with a final scan and the flush; a match yields at most 17 bytes. Output
// stalls hold the emits and the flush. Each copied byte needs a registered
// window read before its emit. The window is not swept on restart: a fill
// count tracks the span written since, and other entries read as zero. Write
// output_length only while no input byte is in progress.

module lzss_ring_decompressor_top #(
    parameter int WINDOW_AW   = lzss_pkg::WINDOW_AW_DEF,
    parameter int MATCH_LEN_W = lzss_pkg::MATCH_LEN_W_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration: output_length
    input  logic                           i_cfg_wr_en,
    input  logic [lzss_pkg::OUT_LEN_W-1:0] i_cfg_wr_data,
    // Compressed input
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] compressed_byte
    input  logic                           s_axis_tuser,   // [0] new_stream
    // Decompressed output
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,   // [7:0] out_byte
    output logic                           m_axis_tlast,   // last_of_run
    output logic                           m_axis_tuser    // [0] stream_done
);

    lzss_pkg::t_dp_cmd  w_cmd;
    lzss_pkg::t_dp_stat w_stat;

    // Step sequencing
    lzss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_restart(s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Bit buffer, window and output stage
    lzss_dp #(
        .WINDOW_AW  (WINDOW_AW),
        .MATCH_LEN_W(MATCH_LEN_W)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_byte    (s_axis_tdata),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_byte   (m_axis_tdata),
        .o_out_last   (m_axis_tlast),
        .o_out_done   (m_axis_tuser)
    );

endmodule

[rtl/lzss_ram.sv]
`timescale 1ns / 1ps

module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/lzss_ctrl.sv]
`timescale 1ns / 1ps

module lzss_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_restart,
    output logic               o_in_ready,
    input  lzss_pkg::t_dp_stat i_stat,
    output lzss_pkg::t_dp_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_COPY  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]                     r_state;
    logic [1:0]                     n_state;
    logic [lzss_pkg::COUNT_W-1:0]   r_count;
    logic [lzss_pkg::COUNT_W-1:0]   n_count;
    logic                           w_limit;
    logic                           w_slot;
    lzss_pkg::t_dp_cmd              w_cmd;

    assign w_limit = (r_count == lzss_pkg::COUNT_W'(lzss_pkg::MAX_RESULTS));
    // A new byte may replace the held one only if the held one can leave
    assign w_slot  = !i_stat.pend_valid || i_stat.out_free;

    // Sequence one input byte through decode, copy and flush
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load    = 1'b1;
                    w_cmd.restart = i_in_restart;
                    n_count       = '0;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.done || w_limit) begin
                    n_state = S_FLUSH;
                end else if (i_stat.copy_pending) begin
                    w_cmd.copy_read = 1'b1;
                    n_state         = S_COPY;
                end else if (i_stat.lit_ready) begin
                    if (w_slot) begin
                        w_cmd.lit_emit = 1'b1;
                        n_count        = r_count + 1'b1;
                    end
                end else if (i_stat.match_ready) begin
                    w_cmd.match_parse = 1'b1;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_COPY: begin
                if (w_slot) begin
                    w_cmd.copy_emit = 1'b1;
                    n_count         = r_count + 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_FLUSH: begin
                if (!i_stat.pend_valid) begin
                    w_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_stat.out_free) begin
                    w_cmd.flush_push = 1'b1;
                    w_cmd.finish     = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and per-step result count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = w_cmd;

endmodule

[rtl/lzss_dp.sv]
`timescale 1ns / 1ps

module lzss_dp #(
    parameter int WINDOW_AW   = lzss_pkg::WINDOW_AW_DEF,
    parameter int MATCH_LEN_W = lzss_pkg::MATCH_LEN_W_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [lzss_pkg::LITERAL_BITS-1:0] i_in_byte,
    input  logic                             i_cfg_wr_en,
    input  logic [lzss_pkg::OUT_LEN_W-1:0]   i_cfg_wr_data,
    input  lzss_pkg::t_dp_cmd                i_cmd,
    output lzss_pkg::t_dp_stat               o_stat,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [lzss_pkg::LITERAL_BITS-1:0] o_out_byte,
    output logic                             o_out_last,
    output logic                             o_out_done
);

    localparam int LIT       = lzss_pkg::LITERAL_BITS;
    localparam int ACC       = lzss_pkg::ACC_CAPACITY;
    localparam int HW        = lzss_pkg::HELD_W;
    localparam int DEPTH     = 1 << WINDOW_AW;
    localparam int FILL_W    = WINDOW_AW + 1;
    localparam int LEN_W     = MATCH_LEN_W + 1;
    localparam int MATCH_TOK = 1 + WINDOW_AW + MATCH_LEN_W;
    localparam int LIT_TOK   = 1 + LIT;
    localparam int TOKW      = (MATCH_TOK > LIT_TOK) ? MATCH_TOK : LIT_TOK;
    localparam logic [WINDOW_AW-1:0] START_POS =
        WINDOW_AW'(lzss_pkg::START_POSITION % DEPTH);

    // Stream state
    logic [ACC-1:0]                  r_acc;
    logic [HW-1:0]                   r_held;
    logic [WINDOW_AW-1:0]            r_wp;
    logic [FILL_W-1:0]               r_fill;
    logic [lzss_pkg::OUT_LEN_W-1:0]  r_produced;
    logic [lzss_pkg::OUT_LEN_W-1:0]  r_out_len;
    logic [WINDOW_AW-1:0]            r_copy_src;
    logic [LEN_W-1:0]                r_copy_left;
    logic                            r_rd_ok;
    // Hold stage and output register
    logic                            r_pend_valid;
    logic [LIT-1:0]                  r_pend;
    logic                            r_pend_done;
    logic                            r_out_valid;
    logic [LIT-1:0]                  r_out_byte;
    logic                            r_out_last;
    logic                            r_out_done;

    logic [ACC-1:0]                  n_acc;
    logic [HW-1:0]                   n_held;
    logic [WINDOW_AW-1:0]            n_wp;
    logic [FILL_W-1:0]               n_fill;
    logic [lzss_pkg::OUT_LEN_W-1:0]  n_produced;
    logic [WINDOW_AW-1:0]            n_copy_src;
    logic [LEN_W-1:0]                n_copy_left;

    logic [ACC+TOKW-1:0]             w_ext;
    logic [TOKW-1:0]                 w_tok;
    logic                            w_flag;
    logic [LIT-1:0]                  w_lit;
    logic [WINDOW_AW-1:0]            w_pos;
    logic [MATCH_LEN_W-1:0]          w_len;
    logic                            w_done;
    logic                            w_emit;
    logic [LIT-1:0]                  w_emit_byte;
    logic [LIT-1:0]                  w_rd_data;
    logic [WINDOW_AW-1:0]            w_src_ofs;
    logic                            w_src_ok;
    logic                            w_push;
    logic                            w_out_free;
    logic [HW-1:0]                   w_base_held;
    logic [lzss_pkg::OUT_LEN_W-1:0]  w_produced_inc;

    // Top bits of the buffer, next token first
    assign w_ext  = {r_acc, {TOKW{1'b0}}};
    assign w_tok  = w_ext[r_held +: TOKW];
    assign w_flag = w_tok[TOKW-1];
    assign w_lit  = w_tok[TOKW-2 -: LIT];
    assign w_pos  = w_tok[TOKW-2 -: WINDOW_AW];
    assign w_len  = w_tok[TOKW-2-WINDOW_AW -: MATCH_LEN_W];

    assign w_done     = (r_produced >= r_out_len);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_emit     = i_cmd.lit_emit || i_cmd.copy_emit;
    assign w_push     = (w_emit && r_pend_valid) || i_cmd.flush_push;

    // Entries outside the span written since restart read as zero
    assign w_src_ofs   = r_copy_src - START_POS;
    assign w_src_ok    = ({1'b0, w_src_ofs} < r_fill);
    assign w_emit_byte = i_cmd.lit_emit ? w_lit : (r_rd_ok ? w_rd_data : '0);

    assign w_produced_inc = r_produced + 1'b1;
    assign w_base_held    = i_cmd.restart ? '0 : r_held;

    // Window memory
    lzss_ram #(
        .WIDTH(LIT),
        .DEPTH(DEPTH)
    ) u_window (
        .i_clk    (i_clk),
        .i_wr_en  (w_emit),
        .i_wr_addr(r_wp),
        .i_wr_data(w_emit_byte),
        .i_rd_en  (i_cmd.copy_read),
        .i_rd_addr(r_copy_src),
        .o_rd_data(w_rd_data)
    );

    // Next stream state
    always_comb begin
        n_acc       = r_acc;
        n_held      = r_held;
        n_wp        = r_wp;
        n_fill      = r_fill;
        n_produced  = r_produced;
        n_copy_src  = r_copy_src;
        n_copy_left = r_copy_left;
        if (i_cmd.load) begin
            if (i_cmd.restart) begin
                n_wp        = START_POS;
                n_fill      = '0;
                n_produced  = '0;
                n_copy_src  = '0;
                n_copy_left = '0;
                n_held      = '0;
            end
            // Drop the byte when the buffer has no room
            if ({1'b0, w_base_held} + (HW+1)'(LIT) <= (HW+1)'(ACC)) begin
                n_acc  = {r_acc[ACC-LIT-1:0], i_in_byte};
                n_held = w_base_held + HW'(LIT);
            end
        end
        if (i_cmd.match_parse) begin
            n_held      = r_held - HW'(MATCH_TOK);
            n_copy_src  = w_pos;
            n_copy_left = LEN_W'(w_len) + LEN_W'(lzss_pkg::MIN_MATCH);
        end
        if (i_cmd.lit_emit) begin
            n_held = r_held - HW'(LIT_TOK);
        end
        if (i_cmd.copy_emit) begin
            n_copy_src  = r_copy_src + 1'b1;
            n_copy_left = r_copy_left - 1'b1;
        end
        if (w_emit) begin
            n_wp       = r_wp + 1'b1;
            n_produced = w_produced_inc;
            if (r_fill != FILL_W'(DEPTH)) begin
                n_fill = r_fill + 1'b1;
            end
        end
        if (i_cmd.finish && w_done) begin
            n_copy_left = '0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= '0;
            r_wp         <= START_POS;
            r_fill       <= '0;
            r_produced   <= '0;
            r_out_len    <= '0;
            r_copy_src   <= '0;
            r_copy_left  <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_held      <= n_held;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_produced  <= n_produced;
            r_copy_src  <= n_copy_src;
            r_copy_left <= n_copy_left;
            if (i_cfg_wr_en) begin
                r_out_len <= i_cfg_wr_data;
            end
            // Hold stage: the newest byte waits until the step shows if it is last
            if (w_emit) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush_push) begin
                r_pend_valid <= 1'b0;
            end
            // Output register
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (i_cmd.copy_read) begin
            r_rd_ok <= w_src_ok;
        end
        if (w_emit) begin
            r_pend      <= w_emit_byte;
            r_pend_done <= (w_produced_inc >= r_out_len);
        end
        if (w_push) begin
            r_out_byte <= r_pend;
            r_out_last <= i_cmd.flush_push;
            r_out_done <= r_pend_done;
        end
    end

    assign o_stat.done         = w_done;
    assign o_stat.copy_pending = (r_copy_left != '0);
    assign o_stat.lit_ready    = (r_held >= HW'(LIT_TOK)) && w_flag;
    assign o_stat.match_ready  = (r_held >= HW'(MATCH_TOK)) && !w_flag;
    assign o_stat.pend_valid   = r_pend_valid;
    assign o_stat.out_free     = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;
    assign o_out_done  = r_out_done;

    // Each emitted byte advances the produced count by one
    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_produced == $past(r_produced) + 1'b1))
        else $error("produced count out of step with emitted bytes");

    // No byte is emitted once the stream has reached its length
    a_no_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> !w_done)
        else $error("byte emitted after stream done");

    // The written span never exceeds the window
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(DEPTH))
        else $error("window fill count beyond depth");

    // A byte moves to the output only when the output register frees up
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_out_free)
        else $error("output register overwritten while stalled");

    // A literal consumes its token bits exactly
    a_lit_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.lit_emit |=> (r_held == $past(r_held) - HW'(LIT_TOK)))
        else $error("literal did not consume its token bits");

endmodule
